// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

// ===== src/kmpq_pkg.sv =====
// Package: types, constants and the record ordering of the keyed max priority queue.
package kmpq_pkg;

	localparam int CAPACITY = 256;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_SILENT_INSERT = 2'd0,
		OP_INSERT_REPORT = 2'd1,
		OP_PEEK          = 2'd2,
		OP_POP           = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_TOP   = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] score;
		logic [15:0] record_id;
		logic [15:0] name_tag;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] top_score;
		logic [15:0] top_id;
		logic [15:0] top_tag;
	} out_t;

	typedef struct packed {
		logic [15:0] score;
		logic [15:0] id;
		logic [15:0] tag;
	} rec_t;

	// Per-cell control broadcast from the top level.
	typedef struct packed {
		logic insert;   // an insert goes into the queue this cycle
		logic pop;      // the head record leaves this cycle
		logic occupied; // the cell holds a record
		logic at_end;   // the cell is the first free one
	} cell_ctl_t;

	// True when a strictly outranks b: higher score, then lower id.
	function automatic logic outranks(input rec_t a, input rec_t b);
		return (a.score > b.score) || ((a.score == b.score) && (a.id < b.id));
	endfunction

endpackage

// ===== src/kmpq_cell.sv =====
// One cell of the sorted chain: holds a record, takes the new one, its left or right neighbor's.
module kmpq_cell import kmpq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  rec_t      new_rec,
	input  rec_t      prev_rec,
	input  logic      prev_le,
	input  rec_t      next_rec,
	output rec_t      rec,
	output logic      le
);

	rec_t rec_q;

	// The new record lands here or further left.
	assign le  = ctl.at_end || (ctl.occupied && outranks(new_rec, rec_q));
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_le) begin
				rec_q <= prev_rec;
			end else if (le) begin
				rec_q <= new_rec;
			end
		end else if (ctl.pop) begin
			rec_q <= next_rec;
		end
	end

endmodule

// ===== src/keyed_max_priority_queue_top.sv =====
// Top level of the keyed max priority queue: a sorted chain of record cells.
//
//  Channel | Signals                         | Direction | Moves
//  --------+---------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, in_data     | input     | one request (operation + record)
//  out     | out_valid, out_ready, out_data  | output    | one status / top record
//
// One request per clock while in_ready is high: every cell updates in the cycle the request is accepted,
// and the result sits in the output register from the next cycle on.
// in_ready drops only while an unclaimed result holds the output register.
// Reset clears the record count and the output valid; cell contents are not reset.
// The chain stays sorted, best record in cell 0, equal scores by lower id, exact ties in arrival order.
module keyed_max_priority_queue_top import kmpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	out_t             out_data_q;

	rec_t              cell_rec [CAPACITY];
	logic [CAPACITY-1:0] cell_le;
	cell_ctl_t         cell_ctl [CAPACITY];

	rec_t  new_rec;
	logic  accept;
	logic  is_insert;
	logic  full;
	logic  empty;
	logic  do_insert;
	logic  do_pop;
	logic  emit;
	out_t  result;

	assign new_rec   = '{score: in_data.score, id: in_data.record_id, tag: in_data.name_tag};
	assign accept    = in_valid && in_ready;
	assign is_insert = (in_data.operation == OP_SILENT_INSERT) ||
	                   (in_data.operation == OP_INSERT_REPORT);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign do_insert = accept && is_insert && !full;
	assign do_pop    = accept && (in_data.operation == OP_POP) && !empty;

	// Hold a new request back only while the output register still holds a result that out_ready does not take.
	assign in_ready  = !out_valid_q || out_ready;

	// Build the chain: each cell sees its left and right neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_ctl[i] = '{
			insert:   do_insert,
			pop:      do_pop,
			occupied: (CNT_W'(i) < count_q),
			at_end:   (CNT_W'(i) == count_q)
		};

		kmpq_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[i]),
			.new_rec  (new_rec),
			.prev_rec ((i == 0) ? new_rec : cell_rec[(i == 0) ? 0 : i - 1]),
			.prev_le  ((i == 0) ? 1'b0 : cell_le[(i == 0) ? 0 : i - 1]),
			.next_rec (cell_rec[(i == CAPACITY - 1) ? i : i + 1]),
			.rec      (cell_rec[i]),
			.le       (cell_le[i])
		);
	end

	// Work out the result from the state the request leaves behind.
	always_comb begin
		emit   = 1'b0;
		result = '0;
		case (in_data.operation)
			OP_SILENT_INSERT, OP_INSERT_REPORT: begin
				if (full) begin
					emit          = 1'b1;
					result.status = ST_FULL;
				end else if (in_data.operation == OP_INSERT_REPORT) begin
					emit   = 1'b1;
					// cell_le[0] says the new record becomes the head.
					if (cell_le[0]) begin
						result = '{ST_TOP, new_rec.score, new_rec.id, new_rec.tag};
					end else begin
						result = '{ST_TOP, cell_rec[0].score, cell_rec[0].id, cell_rec[0].tag};
					end
				end
			end
			OP_PEEK: begin
				emit = 1'b1;
				if (empty) begin
					result.status = ST_EMPTY;
				end else begin
					result = '{ST_TOP, cell_rec[0].score, cell_rec[0].id, cell_rec[0].tag};
				end
			end
			OP_POP: begin
				emit = 1'b1;
				// The new head is the second cell, if there is one.
				if (count_q <= CNT_W'(1)) begin
					result.status = ST_EMPTY;
				end else begin
					result = '{ST_TOP, cell_rec[1].score, cell_rec[1].id, cell_rec[1].tag};
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (do_pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== src/kmpq_checker.sv =====
// Port checker for the keyed max priority queue, bound to the top level.
`include "assert_macros.svh"

module kmpq_checker import kmpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`ASSERT_CLK(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_data), "stalled result changed")
	`ASSERT_CLK(a_status_code, clk, arst_n, out_valid |-> (out_data.status == ST_TOP || out_data.status == ST_EMPTY || out_data.status == ST_FULL), "bad status code")
	`ASSERT_CLK(a_no_top_zero, clk, arst_n, out_valid && (out_data.status != ST_TOP) |-> (out_data.top_score == '0 && out_data.top_id == '0 && out_data.top_tag == '0), "record fields set without a top")
	`ASSERT_CLK(a_peek_answers, clk, arst_n, in_valid && in_ready && (in_data.operation == OP_PEEK || in_data.operation == OP_POP) |=> out_valid, "peek or pop gave no result")

endmodule

bind keyed_max_priority_queue_top kmpq_checker u_kmpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

// Testbench of the keyed max priority queue: directed and random requests against a shadow queue.
import kmpq_pkg::*;

class top_record_tracker;
	rec_t shadow_records[$];   // records held, in arrival order
	out_t awaited_reports[$];  // reports still to come out, oldest first
	int   faults;
	int   reports_checked;

	function int best_slot();
		int best;
		best = 0;
		for (int i = 1; i < shadow_records.size(); i++) begin
			if (shadow_records[i].score > shadow_records[best].score ||
				(shadow_records[i].score == shadow_records[best].score &&
				shadow_records[i].id < shadow_records[best].id)) begin
				best = i;
			end
		end
		return best;
	endfunction

	function out_t top_report();
		out_t rep;
		rec_t rec;
		rep = '0;
		if (shadow_records.size() == 0) begin
			rep.status = ST_EMPTY;
		end else begin
			rec = shadow_records[best_slot()];
			rep.status    = ST_TOP;
			rep.top_score = rec.score;
			rep.top_id    = rec.id;
			rep.top_tag   = rec.tag;
		end
		return rep;
	endfunction

	function void note_request(in_t req);
		rec_t rec;
		out_t rep;
		rec.score = req.score;
		rec.id    = req.record_id;
		rec.tag   = req.name_tag;
		case (op_t'(req.operation))
			OP_SILENT_INSERT, OP_INSERT_REPORT: begin
				if (shadow_records.size() >= CAPACITY) begin
					rep = '0;
					rep.status = ST_FULL;
					awaited_reports.push_back(rep);
				end else begin
					shadow_records.push_back(rec);
					if (op_t'(req.operation) == OP_INSERT_REPORT) begin
						awaited_reports.push_back(top_report());
					end
				end
			end
			OP_PEEK: begin
				awaited_reports.push_back(top_report());
			end
			default: begin
				if (shadow_records.size() != 0) begin
					shadow_records.delete(best_slot());
				end
				awaited_reports.push_back(top_report());
			end
		endcase
	endfunction

	function void flag(string what, out_t want, out_t got);
		faults++;
		if (faults <= 10) begin
			$display("%t %s: expected st=%0d score=%h id=%h tag=%h, got st=%0d score=%h id=%h tag=%h",
				$realtime, what, want.status, want.top_score, want.top_id, want.top_tag,
				got.status, got.top_score, got.top_id, got.top_tag);
		end
	endfunction

	function void check_report(out_t got);
		out_t want;
		reports_checked++;
		if (awaited_reports.size() == 0) begin
			flag("unexpected report", '0, got);
			return;
		end
		want = awaited_reports.pop_front();
		if (got.status !== want.status || got.top_score !== want.top_score ||
			got.top_id !== want.top_id || got.top_tag !== want.top_tag) begin
			flag("report mismatch", want, got);
		end
	endfunction
endclass

module tb;
	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	in_t  in_data   = '0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	out_t out_data;

	top_record_tracker tracker = new();

	bit steady     = 1'b0; // suppress sender gaps while set
	int clk_count  = 0;
	int stall_left = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	always #5 clk = ~clk;

	keyed_max_priority_queue_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Key value: hit both extremes, crowd into a few values when ties are wanted.
	function automatic logic [15:0] key_value(bit tie_prone);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h0000;
		if (r == 1) return 16'hFFFF;
		if (tie_prone) return 16'($urandom_range(0, 3));
		return 16'($urandom);
	endfunction

	// Pick an operation; the pop weight is whatever is left of 100.
	function automatic op_t pick_op(int w_silent, int w_report, int w_peek);
		int r;
		r = $urandom_range(0, 99);
		if (r < w_silent) return OP_SILENT_INSERT;
		if (r < w_silent + w_report) return OP_INSERT_REPORT;
		if (r < w_silent + w_report + w_peek) return OP_PEEK;
		return OP_POP;
	endfunction

	// Drop valid and idle while n is above zero; with n zero, keep valid up for the next request.
	task automatic pause(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Offer one request, hold it until accepted, then note it with the tracker.
	task automatic offer(op_t op, logic [15:0] score, logic [15:0] id, logic [15:0] tag);
		in_t req;
		req.operation = op;
		req.score     = score;
		req.record_id = id;
		req.name_tag  = tag;
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(req);
		pause(steady ? 0 : gap_len());
	endtask

	task automatic offer_random(op_t op, bit tie_prone);
		offer(op, key_value(tie_prone), key_value(tie_prone), 16'($urandom));
	endtask

	// Result side: check each accepted report, then decide out_ready for the next cycle.
	// Stall at random, leave a stall-free window once per period of clk_count, and once hold off for
	// a long stretch so that the output register fills and the input backs up.
	always @(posedge clk) begin
		clk_count <= clk_count + 1;
		if (out_valid && out_ready) begin
			tracker.check_report(out_data);
		end
		if (!hold_done && tracker.reports_checked >= 30) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (clk_count % 600 < 150) begin
			out_ready <= 1'b1;
		end else begin
			stall_left = gap_len();
			out_ready <= (stall_left == 0);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue first: peek and pop both report empty.
		offer(OP_PEEK, 16'h0000, 16'h0000, 16'h0000);
		offer(OP_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// Extremes of every field.
		offer(OP_INSERT_REPORT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		offer(OP_INSERT_REPORT, 16'h0000, 16'h0000, 16'h0000);
		// Same top score, lower id: the silent insert takes over the top.
		offer(OP_SILENT_INSERT, 16'hFFFF, 16'h0000, 16'h1234);
		offer(OP_PEEK, 16'h0000, 16'h0000, 16'h0000);
		// Exact tie: the earlier record stays on top until it is popped.
		offer(OP_INSERT_REPORT, 16'hFFFF, 16'h0000, 16'hAAAA);
		offer(OP_POP, 16'h0000, 16'h0000, 16'h0000);
		offer(OP_POP, 16'h0000, 16'h0000, 16'h0000);
		// Equal scores with the lower id arriving later.
		offer(OP_SILENT_INSERT, 16'h4000, 16'h0009, 16'h5555);
		offer(OP_INSERT_REPORT, 16'h4000, 16'h0003, 16'h00FF);
		offer(OP_POP, 16'h0000, 16'h0000, 16'h0000);
		offer(OP_POP, 16'h0000, 16'h0000, 16'h0000);
		offer(OP_POP, 16'h0000, 16'h0000, 16'h0000);
		// Pop that leaves the queue empty, then pop on empty.
		offer(OP_POP, 16'h0000, 16'h0000, 16'h0000);
		offer(OP_POP, 16'h0000, 16'h0000, 16'h0000);
		offer(OP_SILENT_INSERT, 16'h8000, 16'h8000, 16'h5A5A);
		offer(OP_PEEK, 16'h0000, 16'h0000, 16'h0000);
		offer(OP_POP, 16'h0000, 16'h0000, 16'h0000);

		// Mixed traffic, half of it crowded onto a few keys to force ties.
		repeat (60) offer_random(pick_op(40, 30, 15), 1'($urandom_range(0, 1)));

		// Fill back to back to capacity, then push inserts into the full queue.
		steady = 1'b1;
		while (tracker.shadow_records.size() < CAPACITY) begin
			offer_random(pick_op(90, 10, 0), 1'($urandom_range(0, 1)));
		end
		steady = 1'b0;
		repeat (8) offer_random(pick_op(50, 50, 0), 1'($urandom_range(0, 1)));
		offer(OP_PEEK, 16'h0000, 16'h0000, 16'h0000);

		// Mostly pops, taking the queue well down from full.
		repeat (100) offer_random(pick_op(2, 3, 5), 1'b0);

		repeat (40) offer_random(pick_op(30, 25, 20), 1'($urandom_range(0, 1)));
		in_valid <= 1'b0;

		// Wait for every awaited report, then let the pipe settle.
		while (tracker.awaited_reports.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (tracker.awaited_reports.size() != 0) begin
			$display("%0d reports never arrived", tracker.awaited_reports.size());
		end
		if (tracker.faults == 0 && tracker.awaited_reports.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/kmpq_pkg.sv
src/kmpq_cell.sv
src/keyed_max_priority_queue_top.sv
src/kmpq_checker.sv
tb/sv/tb.sv
